@@ rtl/core/ufcc_pkg.sv @@
package ufcc_pkg;

  // request kinds on the input channel
  typedef enum logic {
    OP_ADD_EDGE = 1'b0,
    OP_CLEAR    = 1'b1
  } opcode_t;

  // ops_needed when spare edges fall short
  localparam logic [10:0] OPS_NONE = 11'h7FF;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // datapath action of one microcode step
  typedef enum logic [3:0] {
    A_ACCEPT,
    A_NONE,
    A_RD_CUR,
    A_STEP_CUR,
    A_RD_WALK,
    A_COMPRESS,
    A_SIDE,
    A_LATCH_A,
    A_LATCH_B,
    A_LINK,
    A_GROW,
    A_SPARE,
    A_CLEAR,
    A_BOOT_END,
    A_EMIT
  } act_t;

  // jump condition of one microcode step
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_CLEAR_OP,
    C_BAD,
    C_NOT_ROOT,
    C_WALK_ROOT,
    C_SIDE0,
    C_SAME,
    C_NOT_LAST,
    C_BOOT,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } cw_t;

  // program addresses
  localparam pc_t P_IDLE     = 4'd0;
  localparam pc_t P_DISPATCH = 4'd1;
  localparam pc_t P_BADCHK   = 4'd2;
  localparam pc_t P_FR_RD    = 4'd3;
  localparam pc_t P_FR_CHK   = 4'd4;
  localparam pc_t P_CP_CHK   = 4'd5;
  localparam pc_t P_CP_WR    = 4'd6;
  localparam pc_t P_SIDE     = 4'd7;
  localparam pc_t P_LATCH_A  = 4'd8;
  localparam pc_t P_LATCH_B  = 4'd9;
  localparam pc_t P_LINK     = 4'd10;
  localparam pc_t P_GROW     = 4'd11;
  localparam pc_t P_SPARE    = 4'd12;
  localparam pc_t P_CLR      = 4'd13;
  localparam pc_t P_CLR_END  = 4'd14;
  localparam pc_t P_OUT      = 4'd15;

  // control store; a step that does not jump goes to the next address,
  // and the last step wraps around to idle
  function automatic cw_t ucode_rom(input pc_t pc);
    cw_t cw;
    case (pc)
      P_IDLE:     cw = '{A_ACCEPT,   C_NO_REQ,    P_IDLE};
      P_DISPATCH: cw = '{A_NONE,     C_CLEAR_OP,  P_CLR};
      P_BADCHK:   cw = '{A_NONE,     C_BAD,       P_OUT};
      P_FR_RD:    cw = '{A_RD_CUR,   C_NEVER,     P_IDLE};
      P_FR_CHK:   cw = '{A_STEP_CUR, C_NOT_ROOT,  P_FR_RD};
      P_CP_CHK:   cw = '{A_RD_WALK,  C_WALK_ROOT, P_SIDE};
      P_CP_WR:    cw = '{A_COMPRESS, C_ALWAYS,    P_CP_CHK};
      P_SIDE:     cw = '{A_SIDE,     C_SIDE0,     P_FR_RD};
      P_LATCH_A:  cw = '{A_LATCH_A,  C_SAME,      P_SPARE};
      P_LATCH_B:  cw = '{A_LATCH_B,  C_NEVER,     P_IDLE};
      P_LINK:     cw = '{A_LINK,     C_NEVER,     P_IDLE};
      P_GROW:     cw = '{A_GROW,     C_ALWAYS,    P_OUT};
      P_SPARE:    cw = '{A_SPARE,    C_ALWAYS,    P_OUT};
      P_CLR:      cw = '{A_CLEAR,    C_NOT_LAST,  P_CLR};
      P_CLR_END:  cw = '{A_BOOT_END, C_BOOT,      P_IDLE};
      P_OUT:      cw = '{A_EMIT,     C_OUT_BUSY,  P_OUT};
      default:    cw = '{A_NONE,     C_ALWAYS,    P_IDLE};
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/core/union_find_connectivity_counter.sv @@
// Disjoint-set forest with union by size and path compression, run by a
// 16-step microcode program over one node memory (parent and tree size per
// node, one read and one write port, registered read). Add-edge requests
// walk the parent chain of each endpoint to its root, then rewrite that
// chain so that each node on it points at the root; a request with an
// endpoint out of range goes straight to its result. A clear request
// rewrites every memory entry, one per cycle; the same clearing pass runs
// after reset, with in_tready low. The result sits in an output register,
// so the next request is taken while it waits. node_count may be written
// at any time the block is idle.
module union_find_connectivity_counter import ufcc_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // node_a[9:0], node_b[19:10], zero fill
  input  logic [0:0]  in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // edge_redundant[0], bad_node[1], ops_needed[12:2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data    // node_count
);

  localparam int IW = $clog2(NODES);      // node index
  localparam int SW = $clog2(NODES + 1);  // tree size and node count
  localparam int CW = $clog2(NODES);      // saturating counters

  typedef struct packed {
    logic [SW-1:0] size;
    logic [IW-1:0] parent;
  } entry_t;

  entry_t node_mem [NODES];

  pc_t           pc_r, pc_nxt;
  logic          boot_r;
  logic [10:0]   node_count_r;
  logic          clr_op_r;
  logic          bad_r;
  logic          red_r;
  logic          side_r;
  logic [IW-1:0] cur_r;
  logic [IW-1:0] walk_r;
  logic [IW-1:0] b_r;
  logic [IW-1:0] ra_r;
  logic [IW-1:0] rb_r;
  logic [SW-1:0] size_a_r;
  logic [SW-1:0] size_b_r;
  logic [CW-1:0] union_r;
  logic [CW-1:0] spare_r;
  logic          out_valid_r;
  logic [15:0]   out_data_r;
  entry_t        rd_r;

  cw_t           cw;
  logic          in_fire;
  logic          take;
  logic          out_free;
  logic [SW-1:0] n_used;
  logic          in_bad;
  logic [IW-1:0] in_a_idx;
  logic [IW-1:0] in_b_idx;
  logic          a_under;
  logic [IW-1:0] child_idx;
  logic [IW-1:0] top_idx;
  logic [SW-1:0] child_size;
  logic [31:0]   nm1;
  logic [31:0]   need;
  logic [10:0]   ops;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          branch;

  assign cw = ucode_rom(pc_r);

  // handshakes
  assign in_tready  = (pc_r == P_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign take       = (cw.act == A_ACCEPT) && in_fire;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // node count in use, clamped to 1..NODES
  always_comb begin
    if (node_count_r == 11'd0) begin
      n_used = SW'(1);
    end else if (32'(node_count_r) > 32'(NODES)) begin
      n_used = SW'(NODES);
    end else begin
      n_used = SW'(node_count_r);
    end
  end

  // endpoint range check on the incoming request
  assign in_bad   = (32'(in_tdata[9:0]) >= 32'(n_used)) ||
                    (32'(in_tdata[19:10]) >= 32'(n_used));
  assign in_a_idx = IW'(in_tdata[9:0]);
  assign in_b_idx = IW'(in_tdata[19:10]);

  // union by size: ties hang the second root under the first
  assign a_under    = (size_a_r < size_b_r);
  assign child_idx  = a_under ? ra_r : rb_r;
  assign top_idx    = a_under ? rb_r : ra_r;
  assign child_size = a_under ? size_a_r : size_b_r;

  // cables still needed, or all ones when spare edges fall short
  always_comb begin
    nm1 = 32'(n_used) - 32'd1;
    if (32'(union_r) >= nm1) begin
      need = 32'd0;
    end else begin
      need = nm1 - 32'(union_r);
    end
    if (32'(spare_r) >= need) begin
      ops = need[10:0];
    end else begin
      ops = OPS_NONE;
    end
  end

  // memory port selection
  always_comb begin
    case (cw.act)
      A_RD_WALK: rd_addr = walk_r;
      A_SIDE:    rd_addr = ra_r;
      A_LATCH_A: rd_addr = rb_r;
      default:   rd_addr = cur_r;
    endcase
    wr_en   = 1'b0;
    wr_addr = walk_r;
    wr_data = '{size: rd_r.size, parent: cur_r};
    case (cw.act)
      A_COMPRESS: begin
        wr_en = 1'b1;
      end
      A_LINK: begin
        wr_en   = 1'b1;
        wr_addr = child_idx;
        wr_data = '{size: child_size, parent: top_idx};
      end
      A_GROW: begin
        wr_en   = 1'b1;
        wr_addr = top_idx;
        wr_data = '{size: SW'(size_a_r + size_b_r), parent: top_idx};
      end
      A_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '{size: SW'(1), parent: walk_r};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // node memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    rd_r <= node_mem[rd_addr];
  end

  // jump condition
  always_comb begin
    case (cw.cond)
      C_NEVER:     branch = 1'b0;
      C_ALWAYS:    branch = 1'b1;
      C_NO_REQ:    branch = !in_fire;
      C_CLEAR_OP:  branch = clr_op_r;
      C_BAD:       branch = bad_r;
      C_NOT_ROOT:  branch = (rd_r.parent != cur_r);
      C_WALK_ROOT: branch = (walk_r == cur_r);
      C_SIDE0:     branch = !side_r;
      C_SAME:      branch = (ra_r == rb_r);
      C_NOT_LAST:  branch = (walk_r != IW'(NODES - 1));
      C_BOOT:      branch = boot_r;
      C_OUT_BUSY:  branch = !out_free;
      default:     branch = 1'b0;
    endcase
    pc_nxt = branch ? cw.target : pc_t'(pc_r + pc_t'(1));
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= P_CLR;
      boot_r       <= 1'b1;
      walk_r       <= '0;
      node_count_r <= 11'd1024;
      out_valid_r  <= 1'b0;
      union_r      <= '0;
      spare_r      <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_valid) begin
        node_count_r <= cfg_data;
      end
      // result valid: set on emit, cleared once taken
      if ((cw.act == A_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cw.act)
        A_ACCEPT: begin
          if (take) begin
            walk_r <= (in_tuser[0] == OP_CLEAR) ? '0 : in_a_idx;
          end
        end
        A_COMPRESS: begin
          walk_r <= rd_r.parent;
        end
        A_SIDE: begin
          if (!side_r) begin
            walk_r <= b_r;
          end
        end
        A_GROW: begin
          if (union_r != CW'(NODES - 1)) begin
            union_r <= union_r + CW'(1);
          end
        end
        A_SPARE: begin
          if (spare_r != CW'(NODES - 1)) begin
            spare_r <= spare_r + CW'(1);
          end
        end
        A_CLEAR: begin
          walk_r  <= walk_r + IW'(1);
          union_r <= '0;
          spare_r <= '0;
        end
        A_BOOT_END: begin
          boot_r <= 1'b0;
        end
        default: begin
          boot_r <= boot_r;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cw.act)
      A_ACCEPT: begin
        if (take) begin
          clr_op_r <= (in_tuser[0] == OP_CLEAR);
          bad_r    <= (in_tuser[0] == OP_ADD_EDGE) && in_bad;
          red_r    <= 1'b0;
          side_r   <= 1'b0;
          cur_r    <= in_a_idx;
          b_r      <= in_b_idx;
        end
      end
      A_STEP_CUR: begin
        if (rd_r.parent != cur_r) begin
          cur_r <= rd_r.parent;
        end
      end
      A_SIDE: begin
        if (!side_r) begin
          ra_r   <= cur_r;
          cur_r  <= b_r;
          side_r <= 1'b1;
        end else begin
          rb_r <= cur_r;
        end
      end
      A_LATCH_A: begin
        size_a_r <= rd_r.size;
      end
      A_LATCH_B: begin
        size_b_r <= rd_r.size;
      end
      A_SPARE: begin
        red_r <= 1'b1;
      end
      A_EMIT: begin
        if (out_free) begin
          out_data_r <= {3'b000, ops, bad_r, red_r};
        end
      end
      default: begin
        red_r <= red_r;
      end
    endcase
  end

endmodule

@@ tb/tb_union_find_connectivity_counter.sv @@
module tb_union_find_connectivity_counter import ufcc_pkg::*; ();

  localparam int NODES = 1024;
  localparam int SPARE_MAX = NODES - 1;

  // one result as carried on out_tdata
  typedef struct packed {
    logic        redundant;
    logic        bad;
    logic [10:0] ops;
  } conn_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  // predicted forest and counters
  int unsigned  forest_parent [NODES];
  int unsigned  forest_size [NODES];
  int unsigned  union_total;
  int unsigned  spare_total;
  logic [10:0]  node_count_reg;

  conn_result_t pending_results [$];
  int           error_count = 0;

  // idling controls for sender and receiver
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int stall_left = 0;
  int hold_cycles = 0;

  union_find_connectivity_counter #(.NODES(NODES)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // forest predictor
  function automatic void reset_forest();
    for (int i = 0; i < NODES; i++) begin
      forest_parent[i] = i;
      forest_size[i] = 1;
    end
    union_total = 0;
    spare_total = 0;
  endfunction

  function automatic int unsigned active_nodes();
    if (node_count_reg < 1) return 1;
    if (node_count_reg > NODES) return NODES;
    return node_count_reg;
  endfunction

  function automatic int unsigned root_of(int unsigned node);
    int unsigned root;
    int unsigned walk;
    int unsigned next;
    root = node;
    while (forest_parent[root] != root) root = forest_parent[root];
    // path compression
    walk = node;
    while (walk != root) begin
      next = forest_parent[walk];
      forest_parent[walk] = root;
      walk = next;
    end
    return root;
  endfunction

  function automatic conn_result_t predict_result(opcode_t op, logic [9:0] a, logic [9:0] b);
    conn_result_t r;
    int unsigned  n;
    int unsigned  ra;
    int unsigned  rb;
    int unsigned  need;
    r = '0;
    n = active_nodes();
    if (op == OP_CLEAR) begin
      reset_forest();
    end else if (a >= n || b >= n) begin
      r.bad = 1'b1;
    end else begin
      ra = root_of(a);
      rb = root_of(b);
      if (ra == rb) begin
        r.redundant = 1'b1;
        if (spare_total < SPARE_MAX) spare_total++;
      end else begin
        // smaller tree goes under the larger, ties under node_a's root
        if (forest_size[ra] < forest_size[rb]) begin
          forest_parent[ra] = rb;
          forest_size[rb] += forest_size[ra];
        end else begin
          forest_parent[rb] = ra;
          forest_size[ra] += forest_size[rb];
        end
        if (union_total < SPARE_MAX) union_total++;
      end
    end
    need = (union_total >= n - 1) ? 0 : n - 1 - union_total;
    r.ops = (spare_total >= need) ? 11'(need) : OPS_NONE;
    return r;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    $error("%s", msg);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    conn_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      stall_left = rx_burst ? 0 : $urandom_range(0, 8);
      if (pending_results.size() == 0) begin
        report_error($sformatf("result 0x%04h with no request pending", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.redundant)
          report_error($sformatf("edge_redundant: expected %0d, got %0d",
                                 want.redundant, out_tdata[0]));
        if (out_tdata[1] !== want.bad)
          report_error($sformatf("bad_node: expected %0d, got %0d",
                                 want.bad, out_tdata[1]));
        if (out_tdata[12:2] !== want.ops)
          report_error($sformatf("ops_needed: expected %0d, got %0d",
                                 $signed(want.ops), $signed(out_tdata[12:2])));
      end
    end
  end

  // result receiver: per-result stalls plus an optional long hold
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // send one request; valid stays high until the next request or a drain
  task automatic send_request(input opcode_t op, input logic [9:0] a, input logic [9:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, b, a};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_result(op, a, b));
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // node_count write, only while idle
  task automatic set_node_count(input logic [10:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    node_count_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // default node count, extreme node indexes, clear
  task automatic test_reset_state();
    send_request(OP_ADD_EDGE, 10'd0, 10'd1023);
    send_request(OP_ADD_EDGE, 10'd1023, 10'd0);
    send_request(OP_ADD_EDGE, 10'd5, 10'd5);
    send_request(OP_ADD_EDGE, 10'h2AA, 10'h155);
    send_request(OP_ADD_EDGE, 10'h155, 10'h3FF);
    send_request(OP_ADD_EDGE, 10'h2AA, 10'd0);
    send_request(OP_CLEAR, 10'h3FF, 10'h3FF);
    send_request(OP_ADD_EDGE, 10'd1023, 10'd1023);
    wait_results_done();
  endtask

  // node count of zero, one, two and above the forest size
  task automatic test_node_count_limits();
    set_node_count(11'd0);
    send_request(OP_ADD_EDGE, 10'd0, 10'd0);
    send_request(OP_ADD_EDGE, 10'd0, 10'd1);
    wait_results_done();
    set_node_count(11'd2047);
    send_request(OP_ADD_EDGE, 10'd1023, 10'd1022);
    wait_results_done();
    set_node_count(11'd1);
    send_request(OP_CLEAR, 10'd0, 10'd0);
    send_request(OP_ADD_EDGE, 10'd1, 10'd0);
    wait_results_done();
    set_node_count(11'd2);
    send_request(OP_ADD_EDGE, 10'd0, 10'd5);
    send_request(OP_ADD_EDGE, 10'd0, 10'd1);
    send_request(OP_ADD_EDGE, 10'd1, 10'd0);
    wait_results_done();
  endtask

  // union count above a lowered node count
  task automatic test_lowered_node_count();
    set_node_count(11'd16);
    send_request(OP_CLEAR, 10'd0, 10'd0);
    for (int i = 1; i < 16; i += 3) send_request(OP_ADD_EDGE, 10'(i - 1), 10'(i));
    send_request(OP_ADD_EDGE, 10'd0, 10'd3);
    wait_results_done();
    set_node_count(11'd3);
    send_request(OP_ADD_EDGE, 10'd2, 10'd1);
    send_request(OP_ADD_EDGE, 10'd15, 10'd0);
    wait_results_done();
  endtask

  // a run of spare edges back to back
  task automatic test_spare_saturation();
    set_node_count(11'd2);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    send_request(OP_CLEAR, 10'd0, 10'd0);
    send_request(OP_ADD_EDGE, 10'd0, 10'd1);
    for (int i = 0; i < 40; i++)
      send_request(OP_ADD_EDGE, 10'($urandom_range(0, 1)), 10'($urandom_range(0, 1)));
    wait_results_done();
    // raising the node count leaves too few spare edges
    set_node_count(11'd1024);
    send_request(OP_ADD_EDGE, 10'd2, 10'd3);
    send_request(OP_ADD_EDGE, 10'd3, 10'd2);
    wait_results_done();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  function automatic logic [9:0] pick_node(int unsigned n, ref logic [9:0] pool [48]);
    if (n <= 64 || $urandom_range(0, 19) == 0) return 10'($urandom_range(0, n - 1));
    return pool[$urandom_range(0, 47)];
  endfunction

  // random edges over varying node counts, with noise and back-pressure
  task automatic test_random_traffic();
    logic [10:0]  counts [11];
    logic [9:0]   pool [48];
    int unsigned  n;
    int           roll;
    logic [9:0]   a;
    logic [9:0]   b;
    counts = '{11'd1024, 11'd8, 11'd2047, 11'd16, 11'd3, 11'd1024, 11'd0,
               11'd33, 11'(0), 11'd5, 11'd64};
    counts[8] = 11'($urandom_range(2, 1024));
    for (int phase = 0; phase < 11; phase++) begin
      set_node_count(counts[phase]);
      n = active_nodes();
      for (int i = 0; i < 48; i++) pool[i] = 10'($urandom_range(0, n - 1));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      // long receiver hold while the sender keeps offering
      if (phase == 5) begin
        tx_burst = 1'b1;
        hold_cycles = 300;
      end
      if ($urandom_range(0, 1) == 1) send_request(OP_CLEAR, 10'($urandom), 10'($urandom));
      for (int i = 0; i < 52; i++) begin
        roll = $urandom_range(0, 99);
        if (phase == 3 && i == 30) wait_results_done();
        if (roll < 3) begin
          send_request(OP_CLEAR, 10'($urandom), 10'($urandom));
        end else if (roll < 13 && n < NODES) begin
          a = pick_node(n, pool);
          b = 10'($urandom_range(n, NODES - 1));
          if ($urandom_range(0, 1) == 1) send_request(OP_ADD_EDGE, b, a);
          else send_request(OP_ADD_EDGE, a, b);
        end else begin
          send_request(OP_ADD_EDGE, pick_node(n, pool), pick_node(n, pool));
        end
      end
      wait_results_done();
    end
  endtask

  initial begin
    node_count_reg = 11'd1024;
    reset_forest();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_node_count_limits();
    test_lowered_node_count();
    test_spare_saturation();
    test_random_traffic();
    wait_results_done();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #(20 * 5000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ufcc_pkg.sv
rtl/core/union_find_connectivity_counter.sv
tb/tb_union_find_connectivity_counter.sv
